FILE: hw/rtl/itar_pkg.sv
// Shared types, constants and helpers for the integer-to-text converter.
// Depends on nothing; used by every module of the block.

package itar_pkg;

    localparam int DATA_W         = 32;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 8;
    localparam int DIV_CNT_W      = $clog2(DATA_W);
    localparam int MAX_DIGITS_DEF = 32;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] DIGIT_MAX   = RADIX_W'(9);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_SIGN,
        ST_LOAD,
        ST_READ,
        ST_SHOW
    } itar_state_t;

    typedef struct packed {
        logic done;
        logic quot_zero;
    } itar_div_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = CHAR_W'(d);
        if (d > DIGIT_MAX)
            return dw - LETTER_OFS + CHAR_LA;
        else
            return dw + CHAR_ZERO;
    endfunction

endpackage

FILE: hw/rtl/itar_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on itar_pkg.

module itar_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [itar_pkg::DATA_W-1:0]    dividend,
    input  logic [itar_pkg::RADIX_W-1:0]   divisor,
    output logic [itar_pkg::DATA_W-1:0]    quotient,
    output logic [itar_pkg::RADIX_W-1:0]   remainder,
    output itar_pkg::itar_div_stat_t       stat
);
    import itar_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    work_reg, work_next;
    logic [RADIX_W-1:0]   rem_reg, rem_next;

    logic [RADIX_W:0] trial;
    logic [RADIX_W:0] diff;
    logic             fits;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    assign trial = {rem_reg, work_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[DATA_W-2:0], fits};
            rem_next  = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
            cnt_next  = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign quotient       = work_reg;
    assign remainder      = rem_reg;
    assign stat.done      = done_reg;
    assign stat.quot_zero = (work_reg == '0);

endmodule

FILE: hw/rtl/itar_digit_store.sv
// Character store: one write port and one registered read port.
// Depends on itar_pkg.

module itar_digit_store #(
    parameter int DEPTH = itar_pkg::MAX_DIGITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [itar_pkg::CHAR_W-1:0]  wdata,
    input  logic [AW-1:0]                raddr,
    output logic [itar_pkg::CHAR_W-1:0]  rdata
);
    import itar_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/int_to_ascii_radix_core.sv
// Top level of the integer-to-text converter: control sequencer, radix register.
// Depends on itar_pkg, itar_divider and itar_digit_store.
//
// Usage: one 32-bit value is taken on the input channel (in_valid/in_ready)
// and its text comes out on the output channel (out_valid/out_ready), one
// character per beat, most significant first, last_char high on the final
// beat. The radix register, which resets to ten, is written with
// radix_we/radix_wdata; the user must write it only while the block is idle,
// as the block itself does not enforce this. Each digit is produced by the
// bit-serial divider: a start step, the shift steps and a hand-over of the
// quotient and remainder. Each character is read from the store through the
// ST_READ and ST_SHOW states. One item is handled at a time; in_ready is
// high only while the block is idle.
// Reset clears the sequencer and sets the radix to ten; the character store
// needs no clearing. When the receiver stalls, the current character and its
// flag hold steady until the beat is taken.

module int_to_ascii_radix_core #(
    parameter int MAX_DIGITS = itar_pkg::MAX_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          radix_we,
    input  logic [itar_pkg::RADIX_W-1:0]  radix_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [itar_pkg::DATA_W-1:0] value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [itar_pkg::CHAR_W-1:0]   character,
    output logic                          last_char
);
    import itar_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    itar_state_t        state_reg, state_next;
    logic [RADIX_W-1:0] radix_reg;
    logic [DATA_W-1:0]  mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      pos_reg, pos_next;

    logic [RADIX_W-1:0] eff_radix;
    logic [DATA_W-1:0]  in_bits;
    logic [CW-1:0]      cnt_dec;
    logic               push_ok;

    logic               div_start;
    logic [DATA_W-1:0]  div_quot;
    logic [RADIX_W-1:0] div_rem;
    itar_div_stat_t     div_stat;

    logic               st_we;
    logic [CHAR_W-1:0]  st_wdata;

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            eff_radix = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            eff_radix = RADIX_MAX;
        else
            eff_radix = radix_reg;
    end

    assign in_bits = DATA_W'(value);
    assign cnt_dec = cnt_reg - CW'(1);
    // Characters beyond the store's depth are dropped; only the low ones stay.
    assign push_ok = (cnt_reg < CW'(MAX_DIGITS));

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        div_start  = 1'b0;
        st_we      = 1'b0;
        st_wdata   = digit_char(div_rem);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cnt_next = '0;
                    if (eff_radix == RADIX_DEC && in_bits[DATA_W-1])
                    begin
                        neg_next = 1'b1;
                        mag_next = '0 - in_bits;
                    end
                    else
                    begin
                        neg_next = 1'b0;
                        mag_next = in_bits;
                    end
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    st_we    = push_ok;
                    mag_next = div_quot;
                    if (push_ok)
                        cnt_next = cnt_reg + CW'(1);
                    state_next = div_stat.quot_zero ? ST_SIGN : ST_START;
                end
            end
            ST_SIGN:
            begin
                st_wdata = CHAR_MINUS;
                if (neg_reg && push_ok)
                begin
                    st_we    = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                pos_next   = cnt_dec[AW-1:0];
                state_next = ST_READ;
            end
            ST_READ:
            begin
                // The store's read register catches up with the new position.
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (pos_reg == '0)
                        state_next = ST_IDLE;
                    else
                    begin
                        pos_next   = pos_reg - AW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            radix_reg <= RADIX_RESET;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
            pos_reg   <= pos_next;
            if (radix_we)
                radix_reg <= radix_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
    end

    itar_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (eff_radix),
        .quotient  (div_quot),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    itar_digit_store #(
        .DEPTH (MAX_DIGITS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (st_wdata),
        .raddr (pos_reg),
        .rdata (character)
    );

    assign last_char = (pos_reg == '0);

endmodule

FILE: hw/rtl/itar_checker.sv
// Port-level checks for the integer-to-text converter, bound to the top level.
// Depends on itar_pkg and int_to_ascii_radix_core.

module itar_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [itar_pkg::CHAR_W-1:0]  character,
    input logic                         last_char
);
    import itar_pkg::*;

    // Input is never taken while a character is still on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready and out_valid high together");

    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid)
        else $error("character offered straight after input beat");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(character) && $stable(last_char)))
        else $error("stalled output beat changed");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_char) |=> in_ready)
        else $error("not idle after final character");

    a_busy_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_char) |=> !in_ready)
        else $error("idle before final character");

endmodule

bind int_to_ascii_radix_core itar_checker u_itar_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last_char (last_char)
);
